FILE: rtl/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg: shared types and constants
// Action codes, the nibble result record and the timing and command constants
// for the character-display nibble sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

  // Number of display lines (1 to 4)
  localparam int unsigned RowCount = 2;
  localparam logic [7:0]  LastRow  = 8'(RowCount - 1);

  typedef enum logic [3:0] {
    ACT_INIT      = 4'd0,
    ACT_CLEAR     = 4'd1,
    ACT_HOME      = 4'd2,
    ACT_CURSOR    = 4'd3,
    ACT_DISP_OFF  = 4'd4,
    ACT_DISP_ON   = 4'd5,
    ACT_BLINK_OFF = 4'd6,
    ACT_BLINK_ON  = 4'd7,
    ACT_ULINE_OFF = 4'd8,
    ACT_ULINE_ON  = 4'd9,
    ACT_SCROLL_L  = 4'd10,
    ACT_SCROLL_R  = 4'd11,
    ACT_WRITE     = 4'd12
  } action_e;

  // Display flag bits
  localparam logic [2:0] FlagDisplay = 3'b100;
  localparam logic [2:0] FlagUline   = 3'b010;
  localparam logic [2:0] FlagBlink   = 3'b001;

  // Command bytes
  localparam logic [7:0] CmdReset    = 8'h03;
  localparam logic [7:0] CmdNibMode  = 8'h02;
  localparam logic [7:0] CmdFuncSet  = 8'h28;
  localparam logic [7:0] CmdClear    = 8'h01;
  localparam logic [7:0] CmdHome     = 8'h02;
  localparam logic [7:0] CmdEntry    = 8'h06;
  localparam logic [7:0] CmdDispCtl  = 8'h08;
  localparam logic [7:0] CmdSetAddr  = 8'h80;
  localparam logic [7:0] CmdScrollL  = 8'h18;
  localparam logic [7:0] CmdScrollR  = 8'h1C;

  // Waits in microseconds
  localparam logic [15:0] WaitPowerUp = 16'd50000;
  localparam logic [12:0] WaitLong    = 13'd5100;
  localparam logic [12:0] WaitMid     = 13'd250;
  localparam logic [12:0] WaitSlow    = 13'd2100;
  localparam logic [12:0] WaitShort   = 13'd100;

  // Init sequence: four reset nibbles, then four bytes
  localparam logic [3:0] InitResetSteps = 4'd4;
  localparam logic [3:0] InitLastStep   = 4'd11;

  // DDRAM start address of each line
  localparam logic [7:0] LineStart [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  // Display control byte after init: display on, cursor and blink off
  localparam logic [7:0] InitBytes [4] = '{CmdFuncSet, CmdDispCtl | {5'd0, FlagDisplay},
                                           CmdClear, CmdEntry};

  // Request held in the input stage
  typedef struct packed {
    action_e    action;
    logic [5:0] column;
    logic [7:0] row;
    logic [7:0] char_code;
    logic [2:0] flags;
  } req_t;

  // One nibble write
  typedef struct packed {
    logic [3:0]  nibble;
    logic        register_select;
    logic [15:0] wait_before_us;
    logic [12:0] wait_after_us;
    logic        last;
  } nib_t;

endpackage

`default_nettype wire

FILE: rtl/lcdseq_decode.sv
// ----------------------------------------------------------------------------
// lcdseq_decode: nibble decoder
// Forms the nibble write for one step of the held request.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_decode (
  input  lcdseq_pkg::req_t req_i,
  input  logic [3:0]       step_i,
  output lcdseq_pkg::nib_t nib_o
);
  import lcdseq_pkg::*;

  logic [3:0] init_idx;
  logic [7:0] row_clamped;
  logic [7:0] byte_val;
  logic       rs;
  logic       slow_low;

  assign init_idx = step_i - InitResetSteps;

  // Byte carried by a two-nibble request
  always_comb begin
    row_clamped = (req_i.row > LastRow) ? LastRow : req_i.row;
    byte_val    = CmdClear;
    rs          = 1'b0;
    slow_low    = 1'b0;
    case (req_i.action)
      ACT_CLEAR: begin
        byte_val = CmdClear;
        slow_low = 1'b1;
      end
      ACT_HOME: begin
        byte_val = CmdHome;
        slow_low = 1'b1;
      end
      ACT_CURSOR: begin
        byte_val = CmdSetAddr | ({2'b00, req_i.column} + LineStart[row_clamped[1:0]]);
      end
      ACT_DISP_OFF, ACT_DISP_ON, ACT_BLINK_OFF, ACT_BLINK_ON,
      ACT_ULINE_OFF, ACT_ULINE_ON: begin
        byte_val = CmdDispCtl | {5'd0, req_i.flags};
      end
      ACT_SCROLL_L: byte_val = CmdScrollL;
      ACT_SCROLL_R: byte_val = CmdScrollR;
      ACT_WRITE: begin
        byte_val = req_i.char_code;
        rs       = 1'b1;
      end
      default: byte_val = CmdClear;
    endcase
  end

  always_comb begin
    nib_o = '0;
    nib_o.wait_after_us = WaitShort;
    if (req_i.action == ACT_INIT) begin
      if (step_i < InitResetSteps) begin
        nib_o.nibble = (step_i == 4'd3) ? CmdNibMode[3:0] : CmdReset[3:0];
        if (step_i == 4'd0) begin
          nib_o.wait_before_us = WaitPowerUp;
        end
        if (step_i < 4'd2) begin
          nib_o.wait_after_us = WaitLong;
        end else if (step_i == 4'd2) begin
          nib_o.wait_after_us = WaitMid;
        end
      end else begin
        nib_o.nibble = init_idx[0] ? InitBytes[init_idx[2:1]][3:0]
                                   : InitBytes[init_idx[2:1]][7:4];
        // low nibble of the clear byte
        if (init_idx == 4'd5) begin
          nib_o.wait_after_us = WaitSlow;
        end
      end
      nib_o.last = (step_i == InitLastStep);
    end else begin
      nib_o.nibble          = step_i[0] ? byte_val[3:0] : byte_val[7:4];
      nib_o.register_select = rs;
      if (step_i[0] && slow_low) begin
        nib_o.wait_after_us = WaitSlow;
      end
      nib_o.last = step_i[0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/char_lcd_nibble_command_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_sequencer: 4-bit character display command sequencer
// Expands display requests into timed nibble writes, high nibble first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per transfer:
//   action, cursor column and row, and the character byte. Output channel
//   (out_valid_o / out_stall_i) carries one nibble write per transfer with
//   its register-select level, wait before and after the enable pulse, and
//   last on the final nibble of the request.
//   A request is registered in the request stage; its nibbles then move
//   to the output register. Throughput: one nibble per cycle while the
//   receiver does not stall; a request has 2 nibbles for most actions and
//   12 for init. The request stage takes the next request in the cycle its
//   last nibble moves to the output register, so requests do not overlap.
//   Unused action codes (13 to 15) are taken and dropped with no output.
//   Reset clears the display flags, the request stage and the output
//   register. When the receiver stalls, the output register holds its
//   nibble and the request stage holds, so the input stalls in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  action_i,
  input  logic [5:0]  column_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  nibble_o,
  output logic        register_select_o,
  output logic [15:0] wait_before_us_o,
  output logic [12:0] wait_after_us_o,
  output logic        last_o
);
  import lcdseq_pkg::*;

  // Display flags kept across requests
  logic [2:0] flags_q, flags_d;
  // Request stage
  logic       req_valid_q;
  req_t       req_q;
  logic [3:0] step_q;
  // Output register
  logic       out_valid_q;
  nib_t       out_q;

  nib_t       nib;
  logic       in_xfer;
  logic       out_adv;
  logic       req_done;
  logic       act_used;

  lcdseq_decode u_decode (
    .req_i  (req_q),
    .step_i (step_q),
    .nib_o  (nib)
  );

  // Output register loads whenever it is empty or being taken
  assign out_adv  = !out_valid_q || !out_stall_i;
  assign req_done = req_valid_q && out_adv && nib.last;
  assign in_stall_o = req_valid_q && !req_done;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign act_used   = (action_i <= 4'(ACT_WRITE));

  // Next display flags for the incoming request
  always_comb begin
    flags_d = flags_q;
    case (action_i)
      ACT_INIT:      flags_d = FlagDisplay;
      ACT_DISP_OFF:  flags_d = flags_q & ~FlagDisplay;
      ACT_DISP_ON:   flags_d = flags_q | FlagDisplay;
      ACT_BLINK_OFF: flags_d = flags_q & ~FlagBlink;
      ACT_BLINK_ON:  flags_d = flags_q | FlagBlink;
      ACT_ULINE_OFF: flags_d = flags_q & ~FlagUline;
      ACT_ULINE_ON:  flags_d = flags_q | FlagUline;
      default:       flags_d = flags_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      req_valid_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Advance through the held request
      if (req_valid_q && out_adv) begin
        step_q <= nib.last ? 4'd0 : step_q + 4'd1;
      end
      // Take a new request and drop unused action codes; otherwise free the
      // stage once its last nibble moves out
      if (in_xfer) begin
        flags_q     <= flags_d;
        req_valid_q <= act_used;
      end else if (req_done) begin
        req_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= req_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.action    <= action_e'(action_i);
      req_q.column    <= column_i;
      req_q.row       <= row_i;
      req_q.char_code <= char_code_i;
      req_q.flags     <= flags_d;
    end
    if (out_adv && req_valid_q) begin
      out_q <= nib;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign nibble_o          = out_q.nibble;
  assign register_select_o = out_q.register_select;
  assign wait_before_us_o  = out_q.wait_before_us;
  assign wait_after_us_o   = out_q.wait_after_us;
  assign last_o            = out_q.last;

  // Step counter rests at zero between requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid_q |-> step_q == 4'd0)
    else $error("step counter not cleared while request stage is empty");

  // Step counter never runs past the init sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= InitLastStep)
    else $error("step counter out of range");

  // Init leaves only the display flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && action_i == 4'(ACT_INIT) |=> flags_q == FlagDisplay)
    else $error("init did not set display flags");

endmodule

`default_nettype wire
